>>> hdl/assert_macros.svh
// Assertion macros shared by the deframer modules.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> hdl/ldf_pkg.sv
// Package for the lidar frame deframer: widths, register indexes and shared types.
// Used by every module of the block; depends on nothing.
package ldf_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int CNT_W      = 11;
	localparam int IDX_W      = 10;
	localparam int ANGLE_W    = 15;
	localparam int DIST_W     = 16;
	localparam int MIS_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;
	localparam int QDEPTH     = 4;
	localparam int QAW        = 2;
	localparam int QCNT_W     = 3;
	localparam int OUT_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_VALUE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROLL_THRESH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_CAPACITY = 2'd2;

	localparam logic [7:0]        SYNC_RESET     = 8'hA5;
	localparam logic [14:0]       THRESH_RESET   = 15'd3200;
	localparam logic [CNT_W-1:0]  CAPACITY_RESET = 11'd1024;
	localparam logic [MIS_W-1:0]  MIS_MAX        = 16'hFFFF;

	typedef enum logic [2:0] {
		POS_SYNC = 3'd0,
		POS_B1   = 3'd1,
		POS_B2   = 3'd2,
		POS_B3   = 3'd3,
		POS_B4   = 3'd4,
		POS_HUNT = 3'd5
	} pos_t;

	typedef struct packed {
		logic [7:0]       sync_value;
		logic [14:0]      rollover_threshold;
		logic [CNT_W-1:0] scan_capacity;
	} cfg_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic [DIST_W-1:0]  distance;
		logic [MIS_W-1:0]   misalign;
	} frame_t;

	typedef struct packed {
		logic               new_scan;
		logic [MIS_W-1:0]   misalign;
		logic [IDX_W-1:0]   index;
		logic               bank;
		logic [DIST_W-1:0]  distance;
		logic [ANGLE_W-1:0] angle;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> hdl/ldf_framer.sv
// Front part of the deframer: hunts for sync, gathers the four payload bytes
// and counts misalignments. Depends on ldf_pkg.
module ldf_framer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ldf_pkg::cfg_t        cfg,
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  logic [7:0]           rx_byte,
	input  ldf_pkg::q_status_t   q_status,
	output logic                 push,
	output ldf_pkg::frame_t      frame
);

	ldf_pkg::pos_t                  pos_q, pos_next;
	logic [23:0]                    field_q;
	logic [ldf_pkg::MIS_W-1:0]      mis_q;
	logic                           accept;
	logic                           is_sync;

	// Only the closing byte needs queue space.
	assign byte_ready = (pos_q != ldf_pkg::POS_B4) || !q_status.full;
	assign accept     = byte_valid && byte_ready;
	assign is_sync    = (rx_byte == cfg.sync_value);
	assign push       = accept && (pos_q == ldf_pkg::POS_B4);

	assign frame.angle    = field_q[15:1];
	assign frame.distance = {rx_byte, field_q[23:16]};
	assign frame.misalign = mis_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= ldf_pkg::POS_SYNC;
		end else if (accept) begin
			pos_q <= pos_next;
		end
	end

	always_comb begin
		case (pos_q)
			ldf_pkg::POS_SYNC: pos_next = is_sync ? ldf_pkg::POS_B1 : ldf_pkg::POS_HUNT;
			ldf_pkg::POS_B1:   pos_next = ldf_pkg::POS_B2;
			ldf_pkg::POS_B2:   pos_next = ldf_pkg::POS_B3;
			ldf_pkg::POS_B3:   pos_next = ldf_pkg::POS_B4;
			ldf_pkg::POS_B4:   pos_next = ldf_pkg::POS_SYNC;
			default:           pos_next = is_sync ? ldf_pkg::POS_B1 : ldf_pkg::POS_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q <= '0;
			mis_q   <= '0;
		end else if (accept) begin
			case (pos_q)
				ldf_pkg::POS_SYNC: begin
					if (is_sync) begin
						field_q <= '0;
					end else if (mis_q != ldf_pkg::MIS_MAX) begin
						mis_q <= mis_q + 1'b1;
					end
				end
				ldf_pkg::POS_B1: field_q[7:0]   <= rx_byte;
				ldf_pkg::POS_B2: field_q[15:8]  <= rx_byte;
				ldf_pkg::POS_B3: field_q[23:16] <= rx_byte;
				ldf_pkg::POS_B4: field_q        <= field_q;
				default: begin
					if (is_sync) begin
						field_q <= '0;
					end
				end
			endcase
		end
	end

endmodule

>>> hdl/ldf_queue.sv
// Short frame queue between the framer and the scan back end.
// Register-based FIFO of ldf_pkg::QDEPTH frames; depends on ldf_pkg.
`include "assert_macros.svh"

module ldf_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ldf_pkg::frame_t      wr_frame,
	input  logic                 pop,
	output ldf_pkg::frame_t      rd_frame,
	output ldf_pkg::q_status_t   status
);

	ldf_pkg::frame_t               mem_q [ldf_pkg::QDEPTH];
	logic [ldf_pkg::QAW-1:0]       wr_ptr_q, rd_ptr_q;
	logic [ldf_pkg::QCNT_W-1:0]    count_q;

	assign status.full  = (count_q == ldf_pkg::QCNT_W'(ldf_pkg::QDEPTH));
	assign status.empty = (count_q == '0);
	assign rd_frame     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && status.full)
	`ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && status.empty)
	`ASSERT_PROP(a_count_bound, clk, arst_n, count_q <= ldf_pkg::QCNT_W'(ldf_pkg::QDEPTH))

endmodule

>>> hdl/ldf_scan.sv
// Back part of the deframer: rollover detection, bank flip, capacity limit
// and the output register. Depends on ldf_pkg.
`include "assert_macros.svh"

module ldf_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ldf_pkg::cfg_t        cfg,
	input  ldf_pkg::q_status_t   q_status,
	input  ldf_pkg::frame_t      frame,
	output logic                 pop,
	output logic                 res_valid,
	input  logic                 res_ready,
	output ldf_pkg::result_t     result
);

	logic [ldf_pkg::ANGLE_W-1:0]   last_angle_q;
	logic                          bank_q;
	logic [ldf_pkg::CNT_W-1:0]     count_q;
	logic                          out_valid_q;
	ldf_pkg::result_t              out_q;

	logic [ldf_pkg::ANGLE_W:0]     angle_sum;
	logic                          roll;
	logic [ldf_pkg::CNT_W-1:0]     limit;
	logic [ldf_pkg::CNT_W-1:0]     count_eff;
	logic                          bank_eff;
	logic                          keep;

	assign pop = !q_status.empty && (!out_valid_q || res_ready);

	assign angle_sum = {1'b0, frame.angle} + {1'b0, cfg.rollover_threshold};
	assign roll      = angle_sum < {1'b0, last_angle_q};
	assign limit     = (cfg.scan_capacity > ldf_pkg::CNT_W'(ldf_pkg::MAX_POINTS))
	                   ? ldf_pkg::CNT_W'(ldf_pkg::MAX_POINTS) : cfg.scan_capacity;
	assign count_eff = roll ? '0 : count_q;
	assign bank_eff  = roll ? !bank_q : bank_q;
	assign keep      = count_eff < limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_angle_q <= '0;
			bank_q       <= 1'b1;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				last_angle_q <= frame.angle;
				bank_q       <= bank_eff;
				count_q      <= keep ? count_eff + 1'b1 : count_eff;
				out_valid_q  <= keep;
			end else if (res_ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && keep) begin
			out_q.angle    <= frame.angle;
			out_q.distance <= frame.distance;
			out_q.bank     <= bank_eff;
			out_q.index    <= count_eff[ldf_pkg::IDX_W-1:0];
			out_q.new_scan <= roll;
			out_q.misalign <= frame.misalign;
		end
	end

	assign res_valid = out_valid_q;
	assign result    = out_q;

	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, pop && out_valid_q && !res_ready)
	`ASSERT_PROP(a_hold_stalled, clk, arst_n,
		out_valid_q && !res_ready |=> out_valid_q && $stable(out_q))
	`ASSERT_PROP(a_roll_clears, clk, arst_n,
		pop && keep && roll |=> out_q.index == '0 && out_q.new_scan)

endmodule

>>> hdl/lidar_frame_deframer.sv
// Lidar frame deframer: one raw link byte per transfer in, one point per stored frame out.
// Throughput: one byte per cycle unless the queue is full at a closing byte.
// A frame of five bytes gives at most one point; it passes the queue, then the output register.
// Rate is set by the byte framer, which classifies one byte per cycle, queue space permitting.
// Reset (arst_n low, asynchronous): registers to defaults, hunting sync, bank 1, counts 0.
// Depends on ldf_pkg, ldf_framer, ldf_queue and ldf_scan.
module lidar_frame_deframer (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ldf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ldf_pkg::CFG_DATA_W-1:0] cfg_data,
	// Byte input stream.
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
	// Point output stream.
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [14:0] angle_q6, [30:15] distance_q2, [31] bank, [41:32] point_index,
	// [57:42] misalign_count, [63:58] zero
	output logic [ldf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                          m_axis_tuser   // [0] new_scan
);

	// Configuration registers. The user must write them only while the block is idle; the block does not
	// enforce this. The front and back parts read them directly without any handoff.
	ldf_pkg::cfg_t       cfg_q;
	ldf_pkg::frame_t     push_frame;
	ldf_pkg::frame_t     pop_frame;
	ldf_pkg::q_status_t  q_status;
	ldf_pkg::result_t    result;
	logic                push;
	logic                pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_value         <= ldf_pkg::SYNC_RESET;
			cfg_q.rollover_threshold <= ldf_pkg::THRESH_RESET;
			cfg_q.scan_capacity      <= ldf_pkg::CAPACITY_RESET;
		end else if (cfg_valid) begin
			// An index past the register list is accepted and ignored.
			case (cfg_index)
				ldf_pkg::REG_SYNC_VALUE:    cfg_q.sync_value <= cfg_data[7:0];
				ldf_pkg::REG_ROLL_THRESH:   cfg_q.rollover_threshold <= cfg_data[14:0];
				ldf_pkg::REG_SCAN_CAPACITY:
					cfg_q.scan_capacity <= cfg_data[ldf_pkg::CNT_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// The framer takes a byte every cycle; only a closing byte waits on queue space.
	ldf_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.byte_valid (s_axis_tvalid),
		.byte_ready (s_axis_tready),
		.rx_byte    (s_axis_tdata),
		.q_status   (q_status),
		.push       (push),
		.frame      (push_frame)
	);

	// The queue lets the byte side keep running while the point side is stalled.
	ldf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_frame (push_frame),
		.pop      (pop),
		.rd_frame (pop_frame),
		.status   (q_status)
	);

	// The back end resolves scan rollover and capacity, then registers the point.
	ldf_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_status  (q_status),
		.frame     (pop_frame),
		.pop       (pop),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.result    (result)
	);

	assign m_axis_tdata = {6'd0, result.misalign, result.index, result.bank,
	                       result.distance, result.angle};
	assign m_axis_tuser = result.new_scan;

endmodule

>>> sim/lidar_frame_deframer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lidar_frame_deframer: raw link bytes in, stored scan points out.
// Every point is predicted by a local model of the framer and the scan banks or typed in the directed table.
// Depends on ldf_pkg and the deframer RTL only.
module lidar_frame_deframer_tb;

	// Cycles allowed after the last expected point before the block counts as idle.
	// A point passes the queue and then the output register when nothing waits ahead of it,
	// and at most four dropped frames remain queued, so this leaves a wide margin.
	localparam int DRAIN_CYCLES = 10;
	// Length of the single long output hold-off that forces the block to stall its input.
	localparam int HOLD_CYCLES = 400;
	// Rejected frames sent in a row to run the misalignment counter up.
	localparam int MIS_FRAMES = 40;
	// Only the first few mismatches are printed; all of them are counted.
	localparam int MAX_REPORTS = 40;
	// The index field can encode one register beyond the list; writing it must do nothing.
	localparam logic [ldf_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// One stored point as it leaves the block.
	typedef struct packed {
		logic [ldf_pkg::ANGLE_W-1:0] angle;
		logic [ldf_pkg::DIST_W-1:0]  distance;
		logic                        bank;
		logic [ldf_pkg::IDX_W-1:0]   index;
		logic                        new_scan;
		logic [ldf_pkg::MIS_W-1:0]   misalign;
	} point_t;

	// One row of the directed stimulus: a byte and, where it is obvious, the point it completes.
	typedef struct packed {
		logic [7:0] rx;
		logic       typed;
		point_t     pt;
	} stim_row_t;

	localparam point_t NO_POINT = '0;

	logic                            clk           = 1'b0;
	logic                            arst_n        = 1'b0;
	logic                            cfg_valid     = 1'b0;
	logic                            cfg_ready;
	logic [ldf_pkg::CFG_IDX_W-1:0]   cfg_index     = '0;
	logic [ldf_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [7:0]                      s_axis_tdata  = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [ldf_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
	logic                            m_axis_tuser;

	lidar_frame_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Local copy of the register file, starting at the reset defaults.
	logic [7:0]                sync_byte   = ldf_pkg::SYNC_RESET;
	logic [14:0]               roll_thresh = ldf_pkg::THRESH_RESET;
	logic [ldf_pkg::CNT_W-1:0] capacity    = ldf_pkg::CAPACITY_RESET;

	// Local copy of the deframer state, starting at its reset values.
	ldf_pkg::pos_t               frame_pos    = ldf_pkg::POS_SYNC;
	logic [31:0]                 gathered     = '0;
	logic [ldf_pkg::ANGLE_W-1:0] prev_angle   = '0;
	logic                        wr_bank      = 1'b1;
	logic [ldf_pkg::CNT_W-1:0]   bank_fill    = '0;
	logic [ldf_pkg::MIS_W-1:0]   misalign_cnt = '0;

	// Points predicted but not yet seen on the output, oldest first.
	point_t expected_points[$];

	int unsigned bytes_sent   = 0;
	int unsigned reg_writes   = 0;
	int unsigned points_seen  = 0;
	int unsigned rollovers    = 0;
	int unsigned dropped      = 0;
	int unsigned stall_cycles = 0;
	int unsigned mismatches   = 0;

	// Running angle word for sweep-like frames; its wrap produces natural rollovers.
	logic [15:0] sweep_word = '0;

	// Output hold-off request from the stimulus, taken once by the receiver process.
	bit          hold_request = 1'b0;
	bit          hold_taken   = 1'b0;
	int          sink_hold    = 0;
	int          sink_wait    = 0;
	logic [31:0] sink_cycle   = '0;

	stim_row_t directed_rows [22] = '{
		// Largest angle and distance word; the first point of the reset bank.
		{8'hA5, 1'b0, NO_POINT},
		{8'hFF, 1'b0, NO_POINT},
		{8'hFF, 1'b0, NO_POINT},
		{8'hFF, 1'b0, NO_POINT},
		{8'hFF, 1'b1, 15'd32767, 16'd65535, 1'b1, 10'd0, 1'b0, 16'd0},
		// Angle exactly one threshold below the last one: no rollover yet.
		// The distance bytes equal the sync value and must be taken as data.
		{8'hA5, 1'b0, NO_POINT},
		{8'hFF, 1'b0, NO_POINT},
		{8'hE6, 1'b0, NO_POINT},
		{8'hA5, 1'b0, NO_POINT},
		{8'hA5, 1'b0, NO_POINT},
		// One unit further down: rollover, bank flip and index restart.
		{8'hA5, 1'b0, NO_POINT},
		{8'hFC, 1'b0, NO_POINT},
		{8'hCD, 1'b0, NO_POINT},
		{8'h00, 1'b0, NO_POINT},
		{8'h00, 1'b0, NO_POINT},
		// Bad sync at a frame boundary counts once; the second stray byte does not count.
		{8'h5A, 1'b0, NO_POINT},
		{8'h00, 1'b0, NO_POINT},
		// Zero angle after the hunt: another rollover, misalignment count now one.
		{8'hA5, 1'b0, NO_POINT},
		{8'h00, 1'b0, NO_POINT},
		{8'h00, 1'b0, NO_POINT},
		{8'h34, 1'b0, NO_POINT},
		{8'h12, 1'b1, 15'd0, 16'h1234, 1'b1, 10'd0, 1'b1, 16'd1}
	};

	// Advances the local deframer by one byte; returns 1 when a point is stored.
	function automatic bit deframe_byte(input logic [7:0] rx, output point_t pt);
		logic [ldf_pkg::ANGLE_W-1:0] ang;
		logic [ldf_pkg::DIST_W-1:0]  dist_word;
		bit                          roll;
		int                          room;
		pt = '0;
		deframe_byte = 1'b0;
		case (frame_pos)
			ldf_pkg::POS_B1, ldf_pkg::POS_B2, ldf_pkg::POS_B3: begin
				gathered[8*(int'(frame_pos)-1) +: 8] = rx;
				frame_pos = ldf_pkg::pos_t'(frame_pos + 3'd1);
			end
			ldf_pkg::POS_B4: begin
				frame_pos = ldf_pkg::POS_SYNC;
				ang       = gathered[15:1];
				dist_word = {rx, gathered[23:16]};
				// Compare as a sum so that no negative difference is formed.
				roll = (int'(ang) + int'(roll_thresh)) < int'(prev_angle);
				room = (int'(capacity) > ldf_pkg::MAX_POINTS) ? ldf_pkg::MAX_POINTS
				       : int'(capacity);
				if (roll) begin
					wr_bank   = ~wr_bank;
					bank_fill = '0;
					rollovers++;
				end
				// The last angle follows every complete frame, stored or not.
				prev_angle = ang;
				if (int'(bank_fill) < room) begin
					pt.angle    = ang;
					pt.distance = dist_word;
					pt.bank     = wr_bank;
					pt.index    = bank_fill[ldf_pkg::IDX_W-1:0];
					pt.new_scan = roll;
					pt.misalign = misalign_cnt;
					bank_fill++;
					deframe_byte = 1'b1;
				end else begin
					dropped++;
				end
			end
			default: begin
				// At a frame boundary or while hunting for sync.
				if (rx == sync_byte) begin
					frame_pos = ldf_pkg::POS_B1;
					gathered  = '0;
				end else begin
					if (frame_pos == ldf_pkg::POS_SYNC && misalign_cnt != ldf_pkg::MIS_MAX)
						misalign_cnt++;
					frame_pos = ldf_pkg::POS_HUNT;
				end
			end
		endcase
	endfunction

	// Idle length: mostly short, sometimes longer, rarely a long pause.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// Offers one byte after an optional idle gap and returns at the edge of its transfer.
	// A byte that follows without a gap keeps tvalid high through the step.
	task automatic send_byte(input logic [7:0] value, input int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Sends one byte and queues the point that it completes, if any.
	task automatic feed(input logic [7:0] value, input bit burst);
		point_t pt;
		int     gap;
		gap = (burst || $urandom_range(0, 99) >= 35) ? 0 : gap_len();
		send_byte(value, gap);
		if (deframe_byte(value, pt))
			expected_points.push_back(pt);
	endtask

	// One register write transfer; the local register copy applies the same masking.
	task automatic write_reg(input logic [ldf_pkg::CFG_IDX_W-1:0] idx,
			input logic [ldf_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			ldf_pkg::REG_SYNC_VALUE:    sync_byte   = val[7:0];
			ldf_pkg::REG_ROLL_THRESH:   roll_thresh = val[14:0];
			ldf_pkg::REG_SCAN_CAPACITY: capacity    = val[ldf_pkg::CNT_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic set_config(input logic [ldf_pkg::CFG_DATA_W-1:0] sync_val,
			input logic [ldf_pkg::CFG_DATA_W-1:0] thresh_val,
			input logic [ldf_pkg::CFG_DATA_W-1:0] cap_val);
		write_reg(ldf_pkg::REG_SYNC_VALUE, sync_val);
		write_reg(ldf_pkg::REG_ROLL_THRESH, thresh_val);
		write_reg(ldf_pkg::REG_SCAN_CAPACITY, cap_val);
		cfg_valid <= 1'b0;
	endtask

	// Stops offering bytes and waits until the block has delivered everything and gone quiet.
	// A trailing byte may leave no point behind, so a fixed margin follows the last point.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly well-formed frames with random content, mixed with stray bytes and
	// truncated frames. Angles either follow a wrapping sweep or jump at random.
	task automatic stream_frames(input int n, input int noise_pct, input bit steady);
		logic [15:0] word;
		int          r;
		int          len;
		bit          burst;
		burst = steady;
		for (int f = 0; f < n; f++) begin
			if (!steady && $urandom_range(0, 15) == 0)
				burst = !burst;
			r = $urandom_range(0, 99);
			if (r < noise_pct) begin
				len = $urandom_range(1, 6);
				repeat (len) feed(8'($urandom_range(0, 255)), burst);
			end else if (r < noise_pct + 4) begin
				// A frame cut short: the next sync byte lands in its payload.
				feed(sync_byte, burst);
				len = $urandom_range(1, 3);
				repeat (len) feed(8'($urandom_range(0, 255)), burst);
			end else begin
				if ($urandom_range(0, 1) == 1) begin
					sweep_word = sweep_word + 16'($urandom_range(0, 700));
					word = sweep_word;
				end else begin
					word = 16'($urandom_range(0, 16'hFFFF));
				end
				feed(sync_byte, burst);
				feed(word[7:0], burst);
				feed(word[15:8], burst);
				word = 16'($urandom_range(0, 16'hFFFF));
				feed(word[7:0], burst);
				feed(word[15:8], burst);
			end
		end
	endtask

	// Receiver: random stalls, stretches of steady acceptance, and one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_hold  = 0;
			sink_wait  = 0;
			sink_cycle = '0;
		end else begin
			sink_cycle++;
			if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				sink_hold  = HOLD_CYCLES;
			end
			if (sink_hold > 0) begin
				sink_hold--;
				m_axis_tready <= 1'b0;
			end else if (sink_wait > 0) begin
				sink_wait--;
				m_axis_tready <= 1'b0;
			end else if (sink_cycle[11:10] == 2'b00 || $urandom_range(0, 99) >= 20) begin
				m_axis_tready <= 1'b1;
			end else begin
				sink_wait = gap_len() - 1;
				m_axis_tready <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Output checker. Values are sampled as they stood before the edge, so the order
	// of processes within the step does not matter.
	always @(posedge clk) begin
		point_t want;
		if (arst_n && s_axis_tvalid && !s_axis_tready)
			stall_cycles++;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_points.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: point expected none, actual tdata %h tuser %b",
						$time, m_axis_tdata, m_axis_tuser);
			end else begin
				want = expected_points.pop_front();
				points_seen++;
				check_field("angle_q6", want.angle, m_axis_tdata[14:0]);
				check_field("distance_q2", want.distance, m_axis_tdata[30:15]);
				check_field("bank", want.bank, m_axis_tdata[31]);
				check_field("point_index", want.index, m_axis_tdata[41:32]);
				check_field("misalign_count", want.misalign, m_axis_tdata[57:42]);
				check_field("tdata padding", 0, m_axis_tdata[63:58]);
				check_field("new_scan", want.new_scan, m_axis_tuser);
			end
		end
	end

	// Main sequence: reset, directed table, then phases of random traffic under
	// different register settings, each applied only once the block is idle.
	initial begin
		point_t      pt;
		logic [7:0]  junk;
		bit          stored;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under the reset settings. Rows with a typed point are
		// checked against that point; the others against the local model.
		foreach (directed_rows[k]) begin
			send_byte(directed_rows[k].rx, $urandom_range(0, 2));
			stored = deframe_byte(directed_rows[k].rx, pt);
			if (directed_rows[k].typed)
				expected_points.push_back(directed_rows[k].pt);
			else if (stored)
				expected_points.push_back(pt);
		end

		// Random traffic under the reset settings.
		stream_frames(100, 10, 1'b0);

		// Sync of zero, zero threshold so that any drop rolls over, room for three points.
		// The upper data bits are set to show that the registers mask them off.
		settle();
		set_config(15'h7F00, 15'd0, 15'h7803);
		stream_frames(60, 15, 1'b0);

		// Sync of 0xFF, largest threshold so that no rollover can happen, and a capacity
		// above the bank size, which the block limits to the bank size.
		// The spare register index is written first and must change nothing.
		settle();
		write_reg(REG_SPARE, 15'h5555);
		set_config(15'h7FFF, 15'h7FFF, 15'h07FF);
		stream_frames(80, 3, 1'b0);

		// Capacity of zero drops every point while rejected frames run the
		// misalignment counter up at full rate.
		settle();
		set_config(15'h003C, 15'd3200, 15'd0);
		for (int i = 0; i < MIS_FRAMES; i++) begin
			junk = 8'($urandom_range(0, 255));
			if (junk == sync_byte)
				junk = ~junk;
			feed(junk, 1'b1);
			feed(sync_byte, 1'b1);
			repeat (4) feed(8'($urandom_range(0, 255)), 1'b1);
		end

		// Capacity of one: each bank keeps a single point, so after the first one
		// only frames that roll over are stored.
		settle();
		set_config(15'(ldf_pkg::SYNC_RESET), 15'd1000, 15'd1);
		stream_frames(40, 10, 1'b0);

		// Random settings.
		settle();
		set_config(15'($urandom_range(0, 255)), 15'($urandom_range(0, 6000)),
			15'($urandom_range(4, 64)));
		stream_frames(40, 10, 1'b0);

		// Back to the defaults, then a gapless burst while the receiver holds off,
		// so the output queue fills and the block stalls its byte input.
		settle();
		set_config(15'(ldf_pkg::SYNC_RESET), 15'(ldf_pkg::THRESH_RESET),
			15'(ldf_pkg::CAPACITY_RESET));
		hold_request <= 1'b1;
		stream_frames(60, 0, 1'b1);
		settle();

		$display("Run covered %0d bytes, %0d register writes, %0d points checked,",
			bytes_sent, reg_writes, points_seen);
		$display("%0d rollovers, %0d dropped points, %0d input stall cycles, misalign %0d.",
			rollovers, dropped, stall_cycles, misalign_cnt);
		if (mismatches == 0 && expected_points.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#40000000;
		$display("Timeout at %0t with %0d points still expected", $time,
			expected_points.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
